[src/led_fx_pkg.sv]
// Shared types and constants for the LED strip effect engine.
// Used by led_fx_front, led_fx_cmdq, led_fx_back and the top level.
// No dependencies.
package led_fx_pkg;

    localparam int LED_COUNT = 16;

    localparam int TICK_W     = 32;
    localparam int HUE_W      = 9;
    localparam int BYTE_W     = 8;
    localparam int MODE_W     = 2;
    localparam int PIX_IDX_W  = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 9;

    // LED counter, wide enough for LED_COUNT-1
    localparam int IDX_W = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;

    localparam logic [TICK_W-1:0] BLINK_TICKS  = 32'd50;
    localparam logic [TICK_W-1:0] BREATH_TICKS = 32'd10;
    localparam logic [TICK_W-1:0] WAVE_TICKS   = 32'd5;
    localparam logic [HUE_W-1:0]  WAVE_STEP    = 9'd5;
    localparam logic [HUE_W-1:0]  HUE_WRAP     = 9'd360;
    localparam logic [BYTE_W-1:0] BYTE_MAX     = 8'd255;

    // Rainbow base hue floor(i*360/N) is built incrementally:
    // quotient step plus a carry from the running remainder.
    localparam int POS_STEP_I = 360 / LED_COUNT;
    localparam int REM_STEP_I = 360 % LED_COUNT;
    localparam int REM_W      = $clog2(2 * LED_COUNT);
    localparam logic [HUE_W-1:0] POS_STEP = HUE_W'(POS_STEP_I);
    localparam logic [REM_W-1:0] REM_STEP = REM_W'(REM_STEP_I);
    localparam logic [REM_W-1:0] REM_N    = REM_W'(LED_COUNT);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(LED_COUNT - 1);

    // Effect modes
    localparam logic [MODE_W-1:0] MODE_STEADY  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_BLINK   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_BREATH  = 2'd2;
    localparam logic [MODE_W-1:0] MODE_RAINBOW = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_POWER_ON = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HUE      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SAT      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_VAL      = 3'd4;

    localparam int CMDQ_DEPTH = 2;
    localparam int CMDQ_PTR_W = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
    localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

    typedef enum logic [1:0] {
        CMD_CLEAR_LAST,     // single clear, ends the frame
        CMD_UNIFORM,        // all LEDs at one color
        CMD_CLEAR_UNIFORM,  // clear, then all LEDs at one color
        CMD_RAINBOW         // per-LED hue wave, hue field holds the offset
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t          kind;
        logic [HUE_W-1:0]   hue;
        logic [BYTE_W-1:0]  sat;
        logic [BYTE_W-1:0]  val;
    } cmd_t;

endpackage

[src/led_fx_front.sv]
// Front end: configuration registers, effect state and tick classification.
// Turns each accepted tick into at most one frame command.
// Depends on led_fx_pkg.
module led_fx_front (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  push,
    input  logic                                  full,
    input  logic [led_fx_pkg::TICK_W-1:0]         tick_now,
    input  logic                                  cfg_valid,
    input  logic [led_fx_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [led_fx_pkg::CFG_DATA_W-1:0]     cfg_data,
    output logic                                  cmd_push,
    output led_fx_pkg::cmd_t                      cmd
);

    logic                               power_on_reg;
    logic [led_fx_pkg::MODE_W-1:0]      effect_mode_reg;
    logic [led_fx_pkg::HUE_W-1:0]       base_hue_reg;
    logic [led_fx_pkg::BYTE_W-1:0]      sat_level_reg;
    logic [led_fx_pkg::BYTE_W-1:0]      val_level_reg;

    logic [led_fx_pkg::TICK_W-1:0]      last_tick_reg, last_tick_next;
    logic                               blink_lit_reg, blink_lit_next;
    logic                               breath_rising_reg, breath_rising_next;
    logic [led_fx_pkg::BYTE_W-1:0]      breath_level_reg, breath_level_next;
    logic [led_fx_pkg::HUE_W-1:0]       wave_offset_reg, wave_offset_next;
    logic                               steady_cleared_reg, steady_cleared_next;

    logic                               accept;
    logic [led_fx_pkg::TICK_W-1:0]      elapsed;
    logic [led_fx_pkg::HUE_W-1:0]       wave_sum;

    assign accept   = push && !full;
    assign elapsed  = tick_now - last_tick_reg;
    assign wave_sum = wave_offset_reg + led_fx_pkg::WAVE_STEP;

    always_comb
    begin
        last_tick_next      = last_tick_reg;
        blink_lit_next      = blink_lit_reg;
        breath_rising_next  = breath_rising_reg;
        breath_level_next   = breath_level_reg;
        wave_offset_next    = wave_offset_reg;
        steady_cleared_next = steady_cleared_reg;
        cmd_push            = 1'b0;
        cmd.kind            = led_fx_pkg::CMD_UNIFORM;
        cmd.hue             = base_hue_reg;
        cmd.sat             = sat_level_reg;
        cmd.val             = val_level_reg;

        if (accept && power_on_reg)
        begin
            unique case (effect_mode_reg)
                led_fx_pkg::MODE_BLINK:
                begin
                    if (elapsed >= led_fx_pkg::BLINK_TICKS)
                    begin
                        blink_lit_next = !blink_lit_reg;
                        last_tick_next = tick_now;
                        cmd_push       = 1'b1;
                        cmd.kind       = blink_lit_reg ? led_fx_pkg::CMD_CLEAR_LAST
                                                       : led_fx_pkg::CMD_UNIFORM;
                    end
                end
                led_fx_pkg::MODE_BREATH:
                begin
                    if (elapsed >= led_fx_pkg::BREATH_TICKS)
                    begin
                        if (breath_rising_reg)
                        begin
                            if (breath_level_reg != led_fx_pkg::BYTE_MAX)
                                breath_level_next = breath_level_reg + 8'd1;
                            if (breath_level_next >= val_level_reg)
                                breath_rising_next = 1'b0;
                        end
                        else
                        begin
                            if (breath_level_reg != '0)
                                breath_level_next = breath_level_reg - 8'd1;
                            if (breath_level_next == '0)
                                breath_rising_next = 1'b1;
                        end
                        last_tick_next = tick_now;
                        cmd_push       = 1'b1;
                        cmd.val        = breath_level_next;
                    end
                end
                led_fx_pkg::MODE_RAINBOW:
                begin
                    if (elapsed >= led_fx_pkg::WAVE_TICKS)
                    begin
                        wave_offset_next = (wave_sum >= led_fx_pkg::HUE_WRAP)
                                         ? wave_sum - led_fx_pkg::HUE_WRAP : wave_sum;
                        last_tick_next   = tick_now;
                    end
                    cmd_push = 1'b1;
                    cmd.kind = led_fx_pkg::CMD_RAINBOW;
                    cmd.hue  = wave_offset_next;
                end
                default:
                begin
                    cmd_push            = 1'b1;
                    cmd.kind            = steady_cleared_reg ? led_fx_pkg::CMD_UNIFORM
                                                             : led_fx_pkg::CMD_CLEAR_UNIFORM;
                    steady_cleared_next = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            power_on_reg       <= 1'b1;
            effect_mode_reg    <= led_fx_pkg::MODE_STEADY;
            base_hue_reg       <= '0;
            sat_level_reg      <= led_fx_pkg::BYTE_MAX;
            val_level_reg      <= led_fx_pkg::BYTE_MAX;
            last_tick_reg      <= '0;
            blink_lit_reg      <= 1'b1;
            breath_rising_reg  <= 1'b1;
            breath_level_reg   <= '0;
            wave_offset_reg    <= '0;
            steady_cleared_reg <= 1'b0;
        end
        else
        begin
            last_tick_reg      <= last_tick_next;
            blink_lit_reg      <= blink_lit_next;
            breath_rising_reg  <= breath_rising_next;
            breath_level_reg   <= breath_level_next;
            wave_offset_reg    <= wave_offset_next;
            steady_cleared_reg <= steady_cleared_next;
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    led_fx_pkg::CFG_POWER_ON: power_on_reg    <= cfg_data[0];
                    led_fx_pkg::CFG_MODE:     effect_mode_reg <= cfg_data[led_fx_pkg::MODE_W-1:0];
                    led_fx_pkg::CFG_HUE:      base_hue_reg    <= cfg_data;
                    led_fx_pkg::CFG_SAT:      sat_level_reg   <= cfg_data[led_fx_pkg::BYTE_W-1:0];
                    led_fx_pkg::CFG_VAL:      val_level_reg   <= cfg_data[led_fx_pkg::BYTE_W-1:0];
                    default: ;
                endcase
            end
        end
    end

endmodule

[src/led_fx_cmdq.sv]
// Short command queue between the front end and the pixel generator.
// Register-array FIFO, CMDQ_DEPTH entries, head visible combinationally.
// Depends on led_fx_pkg.
module led_fx_cmdq (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr_en,
    input  led_fx_pkg::cmd_t    wr_cmd,
    input  logic                rd_en,
    output logic                q_full,
    output logic                q_valid,
    output led_fx_pkg::cmd_t    rd_cmd
);

    led_fx_pkg::cmd_t                   mem [led_fx_pkg::CMDQ_DEPTH];
    logic [led_fx_pkg::CMDQ_PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [led_fx_pkg::CMDQ_PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [led_fx_pkg::CMDQ_CNT_W-1:0]  count_reg, count_next;

    localparam logic [led_fx_pkg::CMDQ_PTR_W-1:0] PTR_LAST =
        led_fx_pkg::CMDQ_PTR_W'(led_fx_pkg::CMDQ_DEPTH - 1);
    localparam logic [led_fx_pkg::CMDQ_CNT_W-1:0] CNT_FULL =
        led_fx_pkg::CMDQ_CNT_W'(led_fx_pkg::CMDQ_DEPTH);

    assign q_full  = (count_reg == CNT_FULL);
    assign q_valid = (count_reg != '0);
    assign rd_cmd  = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en)
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        if (rd_en)
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        if (wr_en && !rd_en)
            count_next = count_reg + 1'b1;
        else if (rd_en && !wr_en)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_ptr_reg] <= wr_cmd;
    end

endmodule

[src/led_fx_back.sv]
// Pixel generator: expands the command at the queue head into result
// transactions through a registered output stage, one per cycle while pop low does not hold it.
// Depends on led_fx_pkg.
module led_fx_back (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  q_valid,
    input  led_fx_pkg::cmd_t                      q_cmd,
    output logic                                  q_pop,
    input  logic                                  pop,
    output logic                                  empty,
    output logic [led_fx_pkg::PIX_IDX_W-1:0]      pixel_index,
    output logic [led_fx_pkg::HUE_W-1:0]          pixel_hue,
    output logic [led_fx_pkg::BYTE_W-1:0]         pixel_sat,
    output logic [led_fx_pkg::BYTE_W-1:0]         pixel_val,
    output logic                                  clear_strip,
    output logic                                  last_of_frame
);

    logic [led_fx_pkg::IDX_W-1:0]   idx_reg, idx_next;
    logic [led_fx_pkg::HUE_W-1:0]   pos_reg, pos_next;
    logic [led_fx_pkg::REM_W-1:0]   rem_reg, rem_next;
    logic                           clr_done_reg, clr_done_next;

    logic                           out_valid_reg, out_valid_next;
    logic [led_fx_pkg::IDX_W-1:0]   out_idx_reg, out_idx_next;
    logic [led_fx_pkg::HUE_W-1:0]   out_hue_reg, out_hue_next;
    logic [led_fx_pkg::BYTE_W-1:0]  out_sat_reg, out_sat_next;
    logic [led_fx_pkg::BYTE_W-1:0]  out_val_reg, out_val_next;
    logic                           out_clr_reg, out_clr_next;
    logic                           out_last_reg, out_last_next;

    logic                           adv;
    logic [led_fx_pkg::REM_W-1:0]   rem_sum;
    logic [led_fx_pkg::HUE_W:0]     hue_sum;
    logic [led_fx_pkg::HUE_W-1:0]   rainbow_hue;
    logic [led_fx_pkg::IDX_W+led_fx_pkg::PIX_IDX_W-1:0] idx_ext;

    assign adv      = !out_valid_reg || pop;
    assign rem_sum  = rem_reg + led_fx_pkg::REM_STEP;
    assign hue_sum  = {1'b0, pos_reg} + {1'b0, q_cmd.hue};
    assign rainbow_hue = (hue_sum >= {1'b0, led_fx_pkg::HUE_WRAP})
                       ? led_fx_pkg::HUE_W'(hue_sum - {1'b0, led_fx_pkg::HUE_WRAP})
                       : hue_sum[led_fx_pkg::HUE_W-1:0];

    always_comb
    begin
        idx_next       = idx_reg;
        pos_next       = pos_reg;
        rem_next       = rem_reg;
        clr_done_next  = clr_done_reg;
        q_pop          = 1'b0;
        out_valid_next = adv ? 1'b0 : out_valid_reg;
        out_idx_next   = out_idx_reg;
        out_hue_next   = out_hue_reg;
        out_sat_next   = out_sat_reg;
        out_val_next   = out_val_reg;
        out_clr_next   = out_clr_reg;
        out_last_next  = out_last_reg;

        if (adv && q_valid)
        begin
            out_valid_next = 1'b1;
            if (q_cmd.kind == led_fx_pkg::CMD_CLEAR_LAST ||
                (q_cmd.kind == led_fx_pkg::CMD_CLEAR_UNIFORM && !clr_done_reg))
            begin
                // strip clear carries zero pixel fields
                out_idx_next  = '0;
                out_hue_next  = '0;
                out_sat_next  = '0;
                out_val_next  = '0;
                out_clr_next  = 1'b1;
                out_last_next = (q_cmd.kind == led_fx_pkg::CMD_CLEAR_LAST);
                if (q_cmd.kind == led_fx_pkg::CMD_CLEAR_LAST)
                    q_pop = 1'b1;
                else
                    clr_done_next = 1'b1;
            end
            else
            begin
                out_idx_next  = idx_reg;
                out_hue_next  = (q_cmd.kind == led_fx_pkg::CMD_RAINBOW) ? rainbow_hue
                                                                        : q_cmd.hue;
                out_sat_next  = q_cmd.sat;
                out_val_next  = q_cmd.val;
                out_clr_next  = 1'b0;
                out_last_next = (idx_reg == led_fx_pkg::IDX_LAST);
                if (idx_reg == led_fx_pkg::IDX_LAST)
                begin
                    q_pop         = 1'b1;
                    idx_next      = '0;
                    pos_next      = '0;
                    rem_next      = '0;
                    clr_done_next = 1'b0;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                    if (rem_sum >= led_fx_pkg::REM_N)
                    begin
                        rem_next = rem_sum - led_fx_pkg::REM_N;
                        pos_next = pos_reg + led_fx_pkg::POS_STEP + 1'b1;
                    end
                    else
                    begin
                        rem_next = rem_sum;
                        pos_next = pos_reg + led_fx_pkg::POS_STEP;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            pos_reg       <= '0;
            rem_reg       <= '0;
            clr_done_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            pos_reg       <= pos_next;
            rem_reg       <= rem_next;
            clr_done_reg  <= clr_done_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_idx_reg  <= out_idx_next;
        out_hue_reg  <= out_hue_next;
        out_sat_reg  <= out_sat_next;
        out_val_reg  <= out_val_next;
        out_clr_reg  <= out_clr_next;
        out_last_reg <= out_last_next;
    end

    assign idx_ext       = {{led_fx_pkg::PIX_IDX_W{1'b0}}, out_idx_reg};
    assign empty         = !out_valid_reg;
    assign pixel_index   = idx_ext[led_fx_pkg::PIX_IDX_W-1:0];
    assign pixel_hue     = out_hue_reg;
    assign pixel_sat     = out_sat_reg;
    assign pixel_val     = out_val_reg;
    assign clear_strip   = out_clr_reg;
    assign last_of_frame = out_last_reg;

endmodule

[src/led_strip_effect_engine.sv]
// LED strip effect engine: steady, blink, breath and rainbow wave effects.
// Holds led_fx_front, led_fx_cmdq and led_fx_back.
// Depends on led_fx_pkg.
//
// Usage:
//   Input side is a queue write: drive tick_now with push; a tick is taken
//   on a clock edge with push high and full low. Each tick yields a frame of
//   0, 1, LED_COUNT or LED_COUNT+1 result transactions.
//   Result side is a queue read: while empty is low the oldest result is on
//   the pixel ports; pop takes it. last_of_frame marks a frame's final result.
//   Configuration: cfg_index/cfg_data with cfg_valid; cfg_ready is always high.
//   Write registers only while no frame is in flight.
// Timing:
//   A tick is classified in the cycle it is taken; its command passes the
//   command queue and the registered output stage before its first result
//   shows. The pixel generator emits one result per cycle unless pop holds
//   the output stage; it sets the sustained rate. Frames queue back to back.
// Reset clears effect state and loads register defaults; output is empty.
// When pop is held low the output stage holds, the command queue fills
// (two frames) and then full rises.
module led_strip_effect_engine (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  push,
    output logic                                  full,
    input  logic [led_fx_pkg::TICK_W-1:0]         tick_now,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [led_fx_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [led_fx_pkg::CFG_DATA_W-1:0]     cfg_data,
    output logic                                  empty,
    input  logic                                  pop,
    output logic [led_fx_pkg::PIX_IDX_W-1:0]      pixel_index,
    output logic [led_fx_pkg::HUE_W-1:0]          pixel_hue,
    output logic [led_fx_pkg::BYTE_W-1:0]         pixel_sat,
    output logic [led_fx_pkg::BYTE_W-1:0]         pixel_val,
    output logic                                  clear_strip,
    output logic                                  last_of_frame
);

    logic               cmd_push;
    led_fx_pkg::cmd_t   cmd_in;
    logic               q_full;
    logic               q_valid;
    logic               q_pop;
    led_fx_pkg::cmd_t   q_cmd;

    assign cfg_ready = 1'b1;
    assign full      = q_full;

    led_fx_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (q_full),
        .tick_now  (tick_now),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd_push  (cmd_push),
        .cmd       (cmd_in)
    );

    led_fx_cmdq u_cmdq (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (cmd_push),
        .wr_cmd  (cmd_in),
        .rd_en   (q_pop),
        .q_full  (q_full),
        .q_valid (q_valid),
        .rd_cmd  (q_cmd)
    );

    led_fx_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_valid),
        .q_cmd         (q_cmd),
        .q_pop         (q_pop),
        .pop           (pop),
        .empty         (empty),
        .pixel_index   (pixel_index),
        .pixel_hue     (pixel_hue),
        .pixel_sat     (pixel_sat),
        .pixel_val     (pixel_val),
        .clear_strip   (clear_strip),
        .last_of_frame (last_of_frame)
    );

    // a frame command never lands in a full queue
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_push |-> !q_full)
        else $error("command written into full queue");

    // generator only retires a command that is present
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid)
        else $error("command queue popped while empty");

    // a strip clear carries zeroed pixel fields
    a_clear_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && clear_strip) |->
            (pixel_index == '0 && pixel_hue == '0 && pixel_sat == '0 && pixel_val == '0))
        else $error("clear result with nonzero pixel fields");

    // a result is produced only for a queued command
    a_out_from_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        (empty && !q_valid) |=> empty)
        else $error("result appeared without a command");

endmodule
